[rtl/core/rfn_pkg.sv]
// Shared types and constants for the fraction normaliser.
package rfn_pkg;

  localparam int MagW = 32;
  localparam int CntW = $clog2(MagW);
  localparam logic [MagW-2:0] MagMax = '1;

  typedef struct packed {
    logic signed [31:0] num_in;
    logic signed [31:0] den_in;
  } rfn_in_t;

  typedef struct packed {
    logic signed [31:0] num_out;
    logic        [30:0] den_out;
  } rfn_out_t;

  typedef struct packed {
    logic            go;
    logic [MagW-1:0] dividend;
    logic [MagW-1:0] divisor;
  } rfn_div_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] quo;
    logic [MagW-1:0] rem;
  } rfn_div_rsp_t;

endpackage

[rtl/core/rfn_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module rfn_divider
  import rfn_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  rfn_div_req_t req,
  output rfn_div_rsp_t rsp
);

  logic [MagW-1:0] rem_r, rem_nxt;
  logic [MagW-1:0] quo_r, quo_nxt;
  logic [MagW-1:0] dvs_r;
  logic [CntW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [MagW+1:0] diff;
  logic            ge;

  always_comb begin
    diff    = {1'b0, rem_r, quo_r[MagW-1]} - {2'b00, dvs_r};
    ge      = ~diff[MagW+1];
    rem_nxt = ge ? diff[MagW-1:0] : {rem_r[MagW-2:0], quo_r[MagW-1]};
    quo_nxt = {quo_r[MagW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go && !run_r) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(MagW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !run_r) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

[rtl/core/rational_fraction_normalizer.sv]
// Fraction reduction to lowest terms by Euclid's remainder loop on a shared divider.
// One transaction is taken when start is high and busy is low. A zero numerator or
// denominator returns 0/1 on out_strobe in the cycle after acceptance. Otherwise each
// division runs on the shared 32-step restoring divider, and a fraction whose Euclid
// loop needs k remainder steps takes k divisions plus two for the reduced terms: k is 1
// when one magnitude divides the other and at most 44 for magnitudes up to 2^31. busy
// stays high until the result strobe; out_strobe lasts one cycle and cannot be held
// off, so the receiver must take the result in that cycle.
module rational_fraction_normalizer
  import rfn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rfn_in_t  in_data,
  output logic     out_strobe,
  output rfn_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GCD  = 4'b0010,
    S_DIVN = 4'b0100,
    S_DIVD = 4'b1000
  } state_t;

  state_t          state_r;
  logic [MagW-1:0] n_r, d_r, g_r, pn_r, op_a_r, op_b_r;
  logic            neg_r;
  logic            go_r;
  logic            strobe_r;
  rfn_out_t        res_r;

  logic [MagW-1:0] n_mag, d_mag;
  logic            accept;
  rfn_div_req_t    div_req;
  rfn_div_rsp_t    div_rsp;
  logic [MagW-2:0] pn_sat, pd_sat;
  logic [MagW-1:0] pn_ext;

  assign accept = start && (state_r == S_IDLE);
  assign n_mag  = in_data.num_in[31] ? (MagW'(0) - in_data.num_in) : in_data.num_in;
  assign d_mag  = in_data.den_in[31] ? (MagW'(0) - in_data.den_in) : in_data.den_in;

  assign div_req.go       = go_r;
  assign div_req.dividend = op_a_r;
  assign div_req.divisor  = op_b_r;

  rfn_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // quotients of 2^31 saturate
  assign pn_sat = pn_r[MagW-1] ? MagMax : pn_r[MagW-2:0];
  assign pd_sat = div_rsp.quo[MagW-1] ? MagMax : div_rsp.quo[MagW-2:0];
  assign pn_ext = {1'b0, pn_sat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      go_r     <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      go_r     <= 1'b0;
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (n_mag == '0 || d_mag == '0) begin
              strobe_r <= 1'b1;
            end else begin
              go_r    <= 1'b1;
              state_r <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (div_rsp.done) begin
            go_r <= 1'b1;
            if (div_rsp.rem == '0) begin
              state_r <= S_DIVN;
            end
          end
        end
        S_DIVN: begin
          if (div_rsp.done) begin
            go_r    <= 1'b1;
            state_r <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_rsp.done) begin
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          n_r   <= n_mag;
          d_r   <= d_mag;
          neg_r <= in_data.num_in[31] ^ in_data.den_in[31];
          res_r <= '{num_out: '0, den_out: 31'd1};
          if (n_mag >= d_mag) begin
            op_a_r <= n_mag;
            op_b_r <= d_mag;
          end else begin
            op_a_r <= d_mag;
            op_b_r <= n_mag;
          end
        end
      end
      S_GCD: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            g_r    <= op_b_r;
            op_a_r <= n_r;
          end else begin
            op_a_r <= op_b_r;
            op_b_r <= div_rsp.rem;
          end
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          pn_r   <= div_rsp.quo;
          op_a_r <= d_r;
          op_b_r <= g_r;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          res_r.num_out <= neg_r ? (MagW'(0) - pn_ext) : pn_ext;
          res_r.den_out <= pd_sat;
        end
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = res_r;

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.den_out != '0)
    else $error("result denominator is zero");

  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.num_out == '0 |-> out_data.den_out == 31'd1)
    else $error("zero numerator without unit denominator");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("accepted transaction neither started nor answered");

  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r != S_IDLE)
    else $error("divider finished with the sequencer idle");

endmodule
